// File: rtl/tsp_annealing_swap_step_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the swap-step core.
// ----------------------------------------------------------------------------
`ifndef TSP_ANNEALING_SWAP_STEP_CORE_MACROS_SVH
`define TSP_ANNEALING_SWAP_STEP_CORE_MACROS_SVH

// same-cycle implication
`define TSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Types, constants and the exponential table of the swap-step core.
// ----------------------------------------------------------------------------
package tsp_pkg;

	localparam int DEF_MAX_CITIES = 64;
	localparam int DEF_DIST_BITS  = 16;

	localparam int CITY_W  = 6;
	localparam int DIN_W   = 16;
	localparam int UNI_W   = 16;
	localparam int TEMP_W  = 48;
	localparam int COST_W  = 22;
	localparam int CNT_W   = 7;
	localparam int KIND_W  = 2;
	localparam int EXP_N   = 20;
	localparam int STEP_W  = 5;
	localparam int IN_W    = 120;
	localparam int OUT_W   = 72;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
	localparam logic [CNT_W-1:0]  CNT_RST  = 7'd64;

	localparam logic [KIND_W-1:0] KIND_WDIST = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WSLOT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EVAL  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_MOVE  = 2'd3;

	typedef enum logic [2:0] {
		TW_NONE,
		TW_A_RD,
		TW_B_TA,
		TW_A_TA,
		TW_B_TB
	} tw_op_t;

	typedef struct packed {
		logic              accept;
		logic              rd_a;
		logic              rd_b;
		tw_op_t            tw;
		logic              cap_a;
		logic              sum_start;
		logic              div_init;
		logic              div_step;
		logic              exp_mul;
		logic              exp_acc;
		logic [STEP_W-1:0] k;
		logic              load_out;
		logic              acc;
		logic              prop_zero;
	} tsp_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              move_ok;
		logic              sum_done;
		logic              fast_acc;
		logic              temp_zero;
		logic              too_big;
		logic              exp_pass;
	} tsp_stat_t;

	// round(2^32 * exp(-2^(k-16)))
	function automatic logic [31:0] exp_tab(input logic [STEP_W-1:0] k);
		logic [31:0] v;
		unique case (k)
			5'd0:    v = 32'd4294901760;
			5'd1:    v = 32'd4294836226;
			5'd2:    v = 32'd4294705160;
			5'd3:    v = 32'd4294443040;
			5'd4:    v = 32'd4293918848;
			5'd5:    v = 32'd4292870656;
			5'd6:    v = 32'd4290775039;
			5'd7:    v = 32'd4286586875;
			5'd8:    v = 32'd4278222805;
			5'd9:    v = 32'd4261543595;
			5'd10:   v = 32'd4228380000;
			5'd11:   v = 32'd4162825044;
			5'd12:   v = 32'd4034748382;
			5'd13:   v = 32'd3790295335;
			5'd14:   v = 32'd3344923893;
			5'd15:   v = 32'd2605029347;
			5'd16:   v = 32'd1580030169;
			5'd17:   v = 32'd581260615;
			5'd18:   v = 32'd78665070;
			5'd19:   v = 32'd1440801;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/tsp_ctrl.sv
// ----------------------------------------------------------------------------
// tsp_ctrl
// Sequencer: swap, tour sum, accept decision, divide and exp steps, output.
// ----------------------------------------------------------------------------
`include "tsp_annealing_swap_step_core_macros.svh"

module tsp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  tsp_pkg::tsp_stat_t st,
	output tsp_pkg::tsp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB, S_SUM_GO, S_SUM_WAIT,
		S_DECIDE, S_DIV, S_EXP_MUL, S_EXP_ACC, S_JUDGE, S_UN_A, S_UN_B, S_FIN
	} state_t;

	localparam logic [tsp_pkg::STEP_W-1:0] K_LAST = tsp_pkg::STEP_W'(tsp_pkg::EXP_N - 1);

	state_t                      state_q;
	logic [tsp_pkg::STEP_W-1:0]  k_q;
	logic                        acc_q;
	logic                        pzero_q;
	logic                        eval_q;
	logic                        m_tvalid_q;
	logic                        out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd           = '0;
		cmd.tw        = tsp_pkg::TW_NONE;
		cmd.k         = k_q;
		cmd.acc       = acc_q;
		cmd.prop_zero = pzero_q;
		cmd.accept    = s_tready && s_tvalid;
		unique case (state_q)
			S_SW_RA:   cmd.rd_a = 1'b1;
			S_SW_RB:   begin
				cmd.rd_b  = 1'b1;
				cmd.cap_a = 1'b1;
			end
			S_SW_WA:   cmd.tw = tsp_pkg::TW_A_RD;
			S_SW_WB:   cmd.tw = tsp_pkg::TW_B_TA;
			S_SUM_GO:  cmd.sum_start = 1'b1;
			S_DECIDE:  cmd.div_init = 1'b1;
			S_DIV:     cmd.div_step = 1'b1;
			S_EXP_MUL: cmd.exp_mul = 1'b1;
			S_EXP_ACC: cmd.exp_acc = 1'b1;
			S_UN_A:    cmd.tw = tsp_pkg::TW_A_TA;
			S_UN_B:    cmd.tw = tsp_pkg::TW_B_TB;
			S_FIN:     cmd.load_out = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			k_q        <= '0;
			acc_q      <= 1'b0;
			pzero_q    <= 1'b0;
			eval_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						acc_q   <= 1'b0;
						eval_q  <= (st.kind == tsp_pkg::KIND_EVAL);
						priority if (st.kind == tsp_pkg::KIND_EVAL) begin
							pzero_q <= 1'b0;
							state_q <= S_SUM_GO;
						end else if (st.kind == tsp_pkg::KIND_MOVE && st.move_ok) begin
							pzero_q <= 1'b0;
							state_q <= S_SW_RA;
						end else begin
							pzero_q <= 1'b1;
							state_q <= S_FIN;
						end
					end
				end
				S_SW_RA:    state_q <= S_SW_RB;
				S_SW_RB:    state_q <= S_SW_WA;
				S_SW_WA:    state_q <= S_SW_WB;
				S_SW_WB:    state_q <= S_SUM_GO;
				S_SUM_GO:   state_q <= S_SUM_WAIT;
				S_SUM_WAIT: begin
					if (st.sum_done) begin
						if (eval_q) begin
							acc_q   <= 1'b1;
							state_q <= S_FIN;
						end else begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					k_q <= '0;
					priority if (st.fast_acc) begin
						acc_q   <= 1'b1;
						state_q <= S_FIN;
					end else if (st.temp_zero || st.too_big) begin
						state_q <= S_UN_A;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (k_q == K_LAST) begin
						k_q     <= '0;
						state_q <= S_EXP_MUL;
					end else begin
						k_q <= k_q + tsp_pkg::STEP_W'(1);
					end
				end
				S_EXP_MUL:  state_q <= S_EXP_ACC;
				S_EXP_ACC: begin
					if (k_q == K_LAST) begin
						state_q <= S_JUDGE;
					end else begin
						k_q     <= k_q + tsp_pkg::STEP_W'(1);
						state_q <= S_EXP_MUL;
					end
				end
				S_JUDGE: begin
					if (st.exp_pass) begin
						acc_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_UN_A;
					end
				end
				S_UN_A:     state_q <= S_UN_B;
				S_UN_B:     state_q <= S_FIN;
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	`TSP_ASSERT_NOW(a_load_slot_free, cmd.load_out, (!m_tvalid_q || m_tready), "result overwrites pending transaction")
	`TSP_ASSERT_NOW(a_sum_done_wait, st.sum_done, (state_q == S_SUM_WAIT), "tour sum finished outside wait")
	`TSP_ASSERT_NEXT(a_accept_busy, (s_tvalid && s_tready), !s_tready, "accepted transaction left block idle")

endmodule

// File: rtl/tsp_dp.sv
// ----------------------------------------------------------------------------
// tsp_dp
// Datapath: matrix and tour memories, tour sum pipeline, divider, exp unit,
// cost registers and output register.
// ----------------------------------------------------------------------------
module tsp_dp #(
	parameter int MAX_CITIES = tsp_pkg::DEF_MAX_CITIES,
	parameter int DIST_BITS  = tsp_pkg::DEF_DIST_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [tsp_pkg::IN_W-1:0]     s_tdata,
	input  logic [tsp_pkg::KIND_W-1:0]   s_tuser,
	output logic [tsp_pkg::OUT_W-1:0]    m_tdata,
	input  logic                         cfg_valid,
	input  logic [tsp_pkg::CNT_W-1:0]    cfg_data,
	input  tsp_pkg::tsp_cmd_t            cmd,
	output tsp_pkg::tsp_stat_t           st
);

	localparam int CB  = $clog2(MAX_CITIES);
	localparam int AW  = $clog2(MAX_CITIES * MAX_CITIES);
	localparam int IW  = (CB > tsp_pkg::CITY_W) ? CB : tsp_pkg::CITY_W;
	localparam int LIM = (MAX_CITIES < 64) ? MAX_CITIES : 64;
	localparam int DW  = (DIST_BITS > tsp_pkg::DIN_W) ? DIST_BITS : tsp_pkg::DIN_W;
	localparam int SW  = ((DIST_BITS > tsp_pkg::COST_W) ? DIST_BITS : tsp_pkg::COST_W) + 1;
	localparam int CW  = tsp_pkg::CITY_W;
	localparam int TW  = tsp_pkg::TEMP_W;
	localparam int KW  = tsp_pkg::COST_W;
	localparam int NW  = tsp_pkg::CNT_W;
	localparam int XN  = tsp_pkg::EXP_N;
	localparam logic [NW-1:0] N_LIM = NW'(LIM);

	function automatic logic city_ok(input logic [CW-1:0] c);
		return (32'(c) < MAX_CITIES);
	endfunction

	function automatic logic [CB-1:0] cidx(input logic [CW-1:0] c);
		return CB'(IW'(c));
	endfunction

	// input fields
	logic [CW-1:0]            f_from, f_to, f_slot, f_scity, f_a, f_b;
	logic [tsp_pkg::DIN_W-1:0] f_dist;
	logic [tsp_pkg::UNI_W-1:0] f_uni;
	logic [TW-1:0]            f_temp;

	assign f_from  = s_tdata[5:0];
	assign f_to    = s_tdata[11:6];
	assign f_dist  = s_tdata[27:12];
	assign f_slot  = s_tdata[33:28];
	assign f_scity = s_tdata[39:34];
	assign f_a     = s_tdata[45:40];
	assign f_b     = s_tdata[51:46];
	assign f_uni   = s_tdata[67:52];
	assign f_temp  = s_tdata[115:68];

	// configuration
	logic [NW-1:0] cc_q;
	logic [NW-1:0] n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cc_q <= tsp_pkg::CNT_RST;
		else if (cfg_valid) cc_q <= cfg_data;
	end

	always_comb begin
		priority if (cc_q < NW'(2)) n_eff = NW'(2);
		else if (cc_q > N_LIM)      n_eff = N_LIM;
		else                        n_eff = cc_q;
	end

	// item registers
	logic [CB-1:0]             a_q, b_q;
	logic [tsp_pkg::UNI_W-1:0] uni_q;
	logic [TW-1:0]             temp_q;
	logic                      pos_eq_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			a_q      <= cidx(f_a);
			b_q      <= cidx(f_b);
			uni_q    <= f_uni;
			temp_q   <= f_temp;
			pos_eq_q <= (f_a == f_b);
		end
	end

	// tour memory
	logic [CW-1:0] tour_mem [MAX_CITIES];
	logic [CW-1:0] tour_rd_q;
	logic [CB-1:0] tour_ra;
	logic [CW-1:0] ta_q, tb_q;
	logic          sum_run_q;
	logic [NW-1:0] i_q;

	always_comb begin
		priority if (cmd.rd_a) tour_ra = a_q;
		else if (cmd.rd_b)     tour_ra = b_q;
		else if (i_q == n_eff) tour_ra = '0;
		else                   tour_ra = CB'(i_q);
	end

	always_ff @(posedge clk) begin
		tour_rd_q <= tour_mem[tour_ra];
		if (cmd.cap_a) ta_q <= tour_rd_q;
		unique case (cmd.tw)
			tsp_pkg::TW_A_RD: begin
				tour_mem[a_q] <= tour_rd_q;
				tb_q          <= tour_rd_q;
			end
			tsp_pkg::TW_B_TA: tour_mem[b_q] <= ta_q;
			tsp_pkg::TW_A_TA: tour_mem[a_q] <= ta_q;
			tsp_pkg::TW_B_TB: tour_mem[b_q] <= tb_q;
			default: begin
				if (cmd.accept && s_tuser == tsp_pkg::KIND_WSLOT && city_ok(f_slot))
					tour_mem[cidx(f_slot)] <= f_scity;
			end
		endcase
	end

	// distance matrix
	logic [DIST_BITS-1:0] mat_mem [MAX_CITIES * MAX_CITIES];
	logic [DIST_BITS-1:0] mat_rd_q;
	logic [AW-1:0]        mat_wa, mat_ra;
	logic [DW-1:0]        dist_ext;
	logic [CW-1:0]        prev_q;

	assign dist_ext = DW'(f_dist);
	assign mat_wa   = AW'(cidx(f_from)) * AW'(MAX_CITIES) + AW'(cidx(f_to));
	assign mat_ra   = AW'(cidx(prev_q)) * AW'(MAX_CITIES) + AW'(cidx(tour_rd_q));

	always_ff @(posedge clk) begin
		mat_rd_q <= mat_mem[mat_ra];
		if (cmd.accept && s_tuser == tsp_pkg::KIND_WDIST && city_ok(f_from) && city_ok(f_to))
			mat_mem[mat_wa] <= dist_ext[DIST_BITS-1:0];
	end

	// tour sum pipeline: tour read, matrix read, accumulate
	logic          v_s1, first_s1, last_s1;
	logic          v_s2, last_s2, zero_s2;
	logic [KW-1:0] sum_q;
	logic          sum_done_q;
	logic [SW-1:0] sum_nx;

	assign sum_nx = SW'(sum_q) + (zero_s2 ? SW'(0) : SW'(mat_rd_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_run_q  <= 1'b0;
			i_q        <= '0;
			v_s1       <= 1'b0;
			first_s1   <= 1'b0;
			last_s1    <= 1'b0;
			v_s2       <= 1'b0;
			last_s2    <= 1'b0;
			zero_s2    <= 1'b0;
			sum_done_q <= 1'b0;
		end else begin
			if (cmd.sum_start) begin
				sum_run_q <= 1'b1;
				i_q       <= '0;
			end else if (sum_run_q) begin
				i_q <= i_q + NW'(1);
				if (i_q == n_eff) sum_run_q <= 1'b0;
			end
			v_s1     <= sum_run_q && !cmd.sum_start;
			first_s1 <= (i_q == '0);
			last_s1  <= (i_q == n_eff);
			v_s2     <= v_s1 && !first_s1;
			last_s2  <= last_s1;
			zero_s2  <= !city_ok(prev_q) || !city_ok(tour_rd_q);
			sum_done_q <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) prev_q <= tour_rd_q;
		if (cmd.sum_start) sum_q <= '0;
		else if (v_s2) sum_q <= (sum_nx > SW'(tsp_pkg::COST_MAX)) ? tsp_pkg::COST_MAX : KW'(sum_nx);
	end

	// cost registers
	logic [KW-1:0] cur_q, best_q;
	logic [KW-1:0] prop, new_cur, new_best;
	logic [KW-1:0] delta;

	assign prop     = cmd.prop_zero ? '0 : sum_q;
	assign new_cur  = cmd.acc ? prop : cur_q;
	assign new_best = (cmd.acc && prop < best_q) ? prop : best_q;
	assign delta    = sum_q - cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= tsp_pkg::COST_MAX;
			best_q <= tsp_pkg::COST_MAX;
		end else if (cmd.load_out) begin
			cur_q  <= new_cur;
			best_q <= new_best;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			m_tdata <= {5'd0, new_best, new_cur, cmd.acc, prop};
	end

	// restoring divider: x = delta * 2^32 / temperature, 20 quotient bits
	logic [TW-1:0] rem_q;
	logic [TW:0]   rem2;
	logic          rem_ge;
	logic [XN-1:0] x_q;

	assign rem2   = {rem_q, 1'b0};
	assign rem_ge = (rem2 >= {1'b0, temp_q});

	// exp by product of table factors, Q0.32
	logic [31:0]   r_q;
	logic          r_one_q;
	logic [63:0]   prod_s1;
	logic [31:0]   tab_k;
	logic [64:0]   rnd;

	assign tab_k = tsp_pkg::exp_tab(cmd.k);
	assign rnd   = {1'b0, prod_s1} + 65'(33'h080000000);

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q   <= TW'({delta, 12'd0});
			x_q     <= '0;
			r_one_q <= 1'b1;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? TW'(rem2 - {1'b0, temp_q}) : rem2[TW-1:0];
			x_q   <= {x_q[XN-2:0], rem_ge};
		end
		if (cmd.exp_mul) prod_s1 <= 64'(r_q) * 64'(tab_k);
		if (cmd.exp_acc && x_q[cmd.k]) begin
			r_q     <= r_one_q ? tab_k : rnd[63:32];
			r_one_q <= 1'b0;
		end
	end

	always_comb begin
		st           = '0;
		st.kind      = s_tuser;
		st.move_ok   = (NW'(f_a) < n_eff) && (NW'(f_b) < n_eff);
		st.sum_done  = sum_done_q;
		st.fast_acc  = pos_eq_q || (sum_q <= cur_q);
		st.temp_zero = (temp_q == '0);
		st.too_big   = (TW'({delta, 12'd0}) >= temp_q);
		st.exp_pass  = r_one_q || (uni_q < r_q[31:16]);
	end

endmodule

// File: rtl/tsp_annealing_swap_step_core.sv
// ----------------------------------------------------------------------------
// tsp_annealing_swap_step_core
// Annealing swap-move engine for a closed travelling-salesman tour.
// ----------------------------------------------------------------------------
// One transaction in, one result out. Distance and tour-slot writes, and a move
// with a position outside the tour, go straight to the result. An evaluation
// is paced by the tour sum, which reads one tour slot and one matrix entry per
// cycle through single memory read ports. A move adds the swap and a decision
// state, and a swap back when rejected; a worse move at nonzero temperature that
// is not rejected outright also runs 20 divider steps, the exp factors and a
// judgement state. A result held on the output stalls the next result until it
// is taken. A new transaction is taken while the previous result waits on the
// output.
// ----------------------------------------------------------------------------
module tsp_annealing_swap_step_core #(
	parameter int MAX_CITIES = tsp_pkg::DEF_MAX_CITIES,
	parameter int DIST_BITS  = tsp_pkg::DEF_DIST_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// from_city, to_city, distance, slot, slot_city, pos_a, pos_b, uniform,
	// temperature, zero pad
	input  logic [tsp_pkg::IN_W-1:0]    s_tdata,
	// kind
	input  logic [tsp_pkg::KIND_W-1:0]  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// proposed_cost, accepted, current_cost, best_cost, zero pad
	output logic [tsp_pkg::OUT_W-1:0]   m_tdata,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tsp_pkg::CNT_W-1:0]   cfg_data
);

	tsp_pkg::tsp_cmd_t  cmd;
	tsp_pkg::tsp_stat_t st;

	assign cfg_ready = 1'b1;

	tsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tsp_dp #(
		.MAX_CITIES (MAX_CITIES),
		.DIST_BITS  (DIST_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
